### rtl/bkrd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bkrd_pkg;

    localparam int unsigned REPORT_SLOTS = 6;
    localparam int unsigned MOD_BITS     = 8;

    typedef logic [7:0] key_code_t;
    typedef logic [7:0] mod_byte_t;

    localparam key_code_t MOD_CODE_BASE = 8'hE0;
    localparam key_code_t ERR_CODE_MAX  = 8'h03;
    localparam key_code_t NO_KEY        = 8'h00;

    typedef struct packed {
        logic load;
        logic held;
    } bkrd_cell_ctl_t;

endpackage

`default_nettype wire

### rtl/bkrd_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bkrd_rpt_if import bkrd_pkg::*; ();
    logic      valid;
    logic      ready;
    mod_byte_t modifiers;
    key_code_t key_slot_0;
    key_code_t key_slot_1;
    key_code_t key_slot_2;
    key_code_t key_slot_3;
    key_code_t key_slot_4;
    key_code_t key_slot_5;

    modport source (
        output valid, modifiers, key_slot_0, key_slot_1, key_slot_2,
               key_slot_3, key_slot_4, key_slot_5,
        input  ready
    );
    modport sink (
        input  valid, modifiers, key_slot_0, key_slot_1, key_slot_2,
               key_slot_3, key_slot_4, key_slot_5,
        output ready
    );
endinterface

interface bkrd_evt_if import bkrd_pkg::*; ();
    logic      valid;
    logic      ready;
    logic      is_release;
    key_code_t key_code;
    mod_byte_t modifier_byte;
    logic      last_event;

    modport source (
        output valid, is_release, key_code, modifier_byte, last_event,
        input  ready
    );
    modport sink (
        input  valid, is_release, key_code, modifier_byte, last_event,
        output ready
    );
endinterface

`default_nettype wire

### rtl/bkrd_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module bkrd_cell import bkrd_pkg::*; #(
    parameter int unsigned SLOTS = 6
) (
    input  logic             clk,
    input  bkrd_cell_ctl_t   ctl,
    input  key_code_t        slot [SLOTS],
    input  logic [SLOTS-1:0] pend_in,
    output logic [SLOTS-1:0] pend_out,
    output key_code_t        key,
    output logic [SLOTS-1:0] hit,
    output logic             gone
);

    key_code_t key_reg;
    key_code_t key_next;

    // take the first pending slot, pass the rest to the next cell
    always_comb
    begin
        logic taken;
        taken    = 1'b0;
        key_next = key_reg;
        pend_out = pend_in;
        for (int j = 0; j < SLOTS; j++)
        begin
            if (pend_in[j] && !taken)
            begin
                taken       = 1'b1;
                key_next    = slot[j];
                pend_out[j] = 1'b0;
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < SLOTS; j++)
        begin
            hit[j] = ctl.held && (slot[j] == key_reg);
        end
        gone = ctl.held && (hit == '0);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            key_reg <= key_next;
        end
    end

    assign key = key_reg;

endmodule

`default_nettype wire

### rtl/bkrd_emit.sv
`timescale 1ns / 1ps
`default_nettype none

module bkrd_emit import bkrd_pkg::*; #(
    parameter int unsigned NEV = 20
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  logic [NEV-1:0]  ld_mask,
    input  logic [NEV-1:0]  ld_rel,
    input  key_code_t       ld_code [NEV],
    input  mod_byte_t       ld_mods,
    output logic            busy,
    bkrd_evt_if.source      evt
);

    logic [NEV-1:0] mask_reg;
    logic [NEV-1:0] mask_next;
    logic [NEV-1:0] rel_reg;
    key_code_t      code_reg [NEV];
    mod_byte_t      mods_reg;

    logic           ovalid_reg;
    logic           ovalid_next;
    logic           orel_reg;
    logic           orel_next;
    key_code_t      ocode_reg;
    key_code_t      ocode_next;
    mod_byte_t      omods_reg;
    logic           olast_reg;
    logic           olast_next;

    logic           out_free;
    logic [NEV-1:0] pick;
    logic [NEV-1:0] rest;

    assign out_free = !ovalid_reg || evt.ready;
    assign pick     = mask_reg & (~mask_reg + NEV'(1));
    assign rest     = mask_reg & ~pick;
    assign busy     = (mask_reg != '0);

    always_comb
    begin
        orel_next  = 1'b0;
        ocode_next = NO_KEY;
        for (int i = 0; i < NEV; i++)
        begin
            if (pick[i])
            begin
                orel_next  = orel_next | rel_reg[i];
                ocode_next = ocode_next | code_reg[i];
            end
        end
        olast_next = (rest == '0);
    end

    always_comb
    begin
        mask_next   = mask_reg;
        ovalid_next = ovalid_reg;
        if (out_free)
        begin
            ovalid_next = busy;
            mask_next   = rest;
        end
        if (load)
        begin
            mask_next = ld_mask;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            mask_reg   <= mask_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rel_reg  <= ld_rel;
            code_reg <= ld_code;
            mods_reg <= ld_mods;
        end
        if (out_free && busy)
        begin
            orel_reg  <= orel_next;
            ocode_reg <= ocode_next;
            omods_reg <= mods_reg;
            olast_reg <= olast_next;
        end
    end

    assign evt.valid         = ovalid_reg;
    assign evt.is_release    = orel_reg;
    assign evt.key_code      = ocode_reg;
    assign evt.modifier_byte = omods_reg;
    assign evt.last_event    = olast_reg;

endmodule

`default_nettype wire

### rtl/boot_keyboard_report_differ.sv
// Boot keyboard report differ.
// rpt (sink): one boot-protocol report per request, a modifier byte and six
//   key slots. evt (source): one key event per request, press or release,
//   with the report's modifier byte; last_event marks a report's final event.
// A row of held-key cells keeps the previous report's nonzero keys; each cell
//   compares its key against all slots and the new report is compacted into
//   the row by handing the pending slots from cell to cell.
// Flow: an accepted report's events are loaded into the emitter's pending mask
//   and leave through the output register, one per cycle while the receiver
//   does not stall. A report that causes no event leaves the block idle, so
//   reports with no change can follow back to back. A report with no change,
//   or with an error code before any press, produces no event.
// A report is taken while the last event of the previous one still waits in
//   the output register.
// Reset: clears held count and held modifiers, drops any pending events.
// Receiver stall: the output register holds its event and the remaining
//   events wait; rpt.ready stays low until all but the last event are out.
`timescale 1ns / 1ps
`default_nettype none

module boot_keyboard_report_differ import bkrd_pkg::*; #(
    parameter int unsigned KEY_SLOTS = 6
) (
    input  logic        clk,
    input  logic        rst_n,
    bkrd_rpt_if.sink    rpt,
    bkrd_evt_if.source  evt
);

    localparam int unsigned ACTIVE = (KEY_SLOTS < REPORT_SLOTS) ? KEY_SLOTS : REPORT_SLOTS;
    localparam int unsigned NEV    = 2 * ACTIVE + MOD_BITS;
    localparam int unsigned CNT_W  = $clog2(ACTIVE + 1);

    logic [CNT_W-1:0]  held_count_reg;
    logic [CNT_W-1:0]  held_count_next;
    mod_byte_t         held_mods_reg;

    key_code_t         slot_all [REPORT_SLOTS];
    key_code_t         slot     [ACTIVE];
    logic [ACTIVE-1:0] nz;
    logic [ACTIVE-1:0] err_upto;
    logic              any_err;
    logic              accept;
    logic              commit;
    logic              busy;

    logic [ACTIVE-1:0] pend  [ACTIVE+1];
    key_code_t         ckey  [ACTIVE];
    logic [ACTIVE-1:0] hit   [ACTIVE];
    logic [ACTIVE-1:0] gone;
    bkrd_cell_ctl_t    cctl  [ACTIVE];

    logic [NEV-1:0]    ev_mask;
    logic [NEV-1:0]    ev_rel;
    key_code_t         ev_code [NEV];

    assign slot_all[0] = rpt.key_slot_0;
    assign slot_all[1] = rpt.key_slot_1;
    assign slot_all[2] = rpt.key_slot_2;
    assign slot_all[3] = rpt.key_slot_3;
    assign slot_all[4] = rpt.key_slot_4;
    assign slot_all[5] = rpt.key_slot_5;

    assign rpt.ready = !busy;
    assign accept    = rpt.valid && rpt.ready;
    assign commit    = accept && !any_err;

    always_comb
    begin
        logic err_run;
        err_run         = 1'b0;
        held_count_next = '0;
        for (int j = 0; j < ACTIVE; j++)
        begin
            slot[j]         = slot_all[j];
            nz[j]           = (slot_all[j] != NO_KEY);
            err_run         = err_run | (nz[j] && (slot_all[j] <= ERR_CODE_MAX));
            err_upto[j]     = err_run;
            held_count_next = held_count_next + CNT_W'(nz[j]);
        end
        any_err = err_run;
    end

    assign pend[0] = nz;

    for (genvar k = 0; k < ACTIVE; k++)
    begin : g_cell
        assign cctl[k].load = commit;
        assign cctl[k].held = (CNT_W'(k) < held_count_reg);

        bkrd_cell #(
            .SLOTS (ACTIVE)
        ) u_cell (
            .clk      (clk),
            .ctl      (cctl[k]),
            .slot     (slot),
            .pend_in  (pend[k]),
            .pend_out (pend[k+1]),
            .key      (ckey[k]),
            .hit      (hit[k]),
            .gone     (gone[k])
        );
    end

    always_comb
    begin
        logic [ACTIVE-1:0] seen;
        seen = '0;
        for (int k = 0; k < ACTIVE; k++)
        begin
            seen = seen | hit[k];
        end
        for (int j = 0; j < ACTIVE; j++)
        begin
            ev_mask[j] = nz[j] && !err_upto[j] && !seen[j];
            ev_rel[j]  = 1'b0;
            ev_code[j] = slot[j];
        end
        for (int k = 0; k < ACTIVE; k++)
        begin
            ev_mask[ACTIVE+k] = !any_err && gone[k];
            ev_rel[ACTIVE+k]  = 1'b1;
            ev_code[ACTIVE+k] = ckey[k];
        end
        for (int m = 0; m < MOD_BITS; m++)
        begin
            ev_mask[2*ACTIVE+m] = !any_err && (rpt.modifiers[m] != held_mods_reg[m]);
            ev_rel[2*ACTIVE+m]  = held_mods_reg[m];
            ev_code[2*ACTIVE+m] = MOD_CODE_BASE | key_code_t'(m);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count_reg <= '0;
            held_mods_reg  <= '0;
        end
        else if (commit)
        begin
            held_count_reg <= held_count_next;
            held_mods_reg  <= rpt.modifiers;
        end
    end

    bkrd_emit #(
        .NEV (NEV)
    ) u_emit (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (accept),
        .ld_mask (ev_mask),
        .ld_rel  (ev_rel),
        .ld_code (ev_code),
        .ld_mods (rpt.modifiers),
        .busy    (busy),
        .evt     (evt)
    );

endmodule

`default_nettype wire

### rtl/bkrd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module bkrd_checker import bkrd_pkg::*; (
    input logic      clk,
    input logic      rst_n,
    input logic      rpt_ready,
    input logic      evt_valid,
    input logic      evt_ready,
    input logic      evt_is_release,
    input key_code_t evt_key_code,
    input mod_byte_t evt_modifier_byte,
    input logic      evt_last_event
);

    // stalled event holds its payload
    a_evt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && !evt_ready |=> evt_valid && $stable(evt_key_code)
            && $stable(evt_is_release) && $stable(evt_modifier_byte)
            && $stable(evt_last_event))
        else $error("event changed while stalled");

    // no new report while more than the final event is outstanding
    a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && !evt_last_event |-> !rpt_ready)
        else $error("report taken while events pending");

    // events of one report follow back to back with the same modifier byte
    a_same_mods: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && evt_ready && !evt_last_event |=> evt_valid
            && (evt_modifier_byte == $past(evt_modifier_byte)))
        else $error("report events broken up");

    a_reset: assert property (@(posedge clk)
        !rst_n |-> !evt_valid)
        else $error("event valid during reset");

endmodule

bind boot_keyboard_report_differ bkrd_checker u_bkrd_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .rpt_ready         (rpt.ready),
    .evt_valid         (evt.valid),
    .evt_ready         (evt.ready),
    .evt_is_release    (evt.is_release),
    .evt_key_code      (evt.key_code),
    .evt_modifier_byte (evt.modifier_byte),
    .evt_last_event    (evt.last_event)
);

`default_nettype wire

### bench/tb_boot_keyboard_report_differ.sv
`timescale 1ns / 1ps

module tb_boot_keyboard_report_differ;
    import bkrd_pkg::*;

    localparam logic        KEY_PRESS    = 1'b0;
    localparam logic        KEY_RELEASE  = 1'b1;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned RANDOM_ITEMS = 112;
    localparam int unsigned MAX_IDLE     = 5;
    localparam int unsigned SETTLE       = 25;

    typedef struct {
        mod_byte_t   mods;
        key_code_t   slot [REPORT_SLOTS];
        int unsigned gap;
        bit          drain;
    } report_t;

    typedef struct {
        logic      is_release;
        key_code_t key_code;
        mod_byte_t modifier_byte;
        logic      last_event;
    } key_event_t;

    logic clk;
    logic rst_n;

    bkrd_rpt_if rpt_if ();
    bkrd_evt_if evt_if ();

    boot_keyboard_report_differ u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .rpt   (rpt_if),
        .evt   (evt_if)
    );

    report_t     queued_reports [$];
    key_event_t  due_events [$];
    report_t     on_wire;
    report_t     last_queued;
    key_code_t   down_keys [REPORT_SLOTS];
    int unsigned down_count;
    mod_byte_t   down_mods;
    int unsigned reports_taken;
    int unsigned total_reports;
    int unsigned events_seen;
    int unsigned error_count;
    int unsigned idle_cycles;
    int unsigned stall_cycles;
    int unsigned stall_draw;
    int unsigned cycle_count;
    bit          quiet_sender;

    function automatic key_event_t make_event(input logic rel, input key_code_t code,
                                              input mod_byte_t mods);
        key_event_t e;
        e.is_release    = rel;
        e.key_code      = code;
        e.modifier_byte = mods;
        e.last_event    = 1'b0;
        return e;
    endfunction

    function automatic void diff_report(input report_t r);
        key_event_t  evs [$];
        logic        hit;
        logic        rejected;
        int unsigned kept;
        int          i;
        int          j;
        rejected = 1'b0;
        for (i = 0; i < REPORT_SLOTS; i++)
        begin
            if (!rejected && r.slot[i] != NO_KEY)
            begin
                if (r.slot[i] <= ERR_CODE_MAX)
                begin
                    rejected = 1'b1;
                end
                else
                begin
                    hit = 1'b0;
                    for (j = 0; j < down_count; j++)
                    begin
                        if (down_keys[j] == r.slot[i])
                            hit = 1'b1;
                    end
                    if (!hit)
                        evs.push_back(make_event(KEY_PRESS, r.slot[i], r.mods));
                end
            end
        end
        if (!rejected)
        begin
            for (i = 0; i < down_count; i++)
            begin
                hit = 1'b0;
                for (j = 0; j < REPORT_SLOTS; j++)
                begin
                    if (r.slot[j] == down_keys[i])
                        hit = 1'b1;
                end
                if (!hit)
                    evs.push_back(make_event(KEY_RELEASE, down_keys[i], r.mods));
            end
            for (i = 0; i < MOD_BITS; i++)
            begin
                if (r.mods[i] && !down_mods[i])
                    evs.push_back(make_event(KEY_PRESS, MOD_CODE_BASE + 8'(i), r.mods));
                if (!r.mods[i] && down_mods[i])
                    evs.push_back(make_event(KEY_RELEASE, MOD_CODE_BASE + 8'(i), r.mods));
            end
            kept = 0;
            for (i = 0; i < REPORT_SLOTS; i++)
            begin
                if (r.slot[i] != NO_KEY)
                begin
                    down_keys[kept] = r.slot[i];
                    kept++;
                end
            end
            down_count = kept;
            down_mods  = r.mods;
        end
        if (evs.size() != 0)
            evs[evs.size() - 1].last_event = 1'b1;
        foreach (evs[k])
            due_events.push_back(evs[k]);
    endfunction

    function automatic report_t build(input mod_byte_t m, input key_code_t s0,
                                      input key_code_t s1, input key_code_t s2,
                                      input key_code_t s3, input key_code_t s4,
                                      input key_code_t s5);
        report_t r;
        r.mods    = m;
        r.slot[0] = s0;
        r.slot[1] = s1;
        r.slot[2] = s2;
        r.slot[3] = s3;
        r.slot[4] = s4;
        r.slot[5] = s5;
        r.gap     = 0;
        r.drain   = 1'b0;
        return r;
    endfunction

    function automatic void queue_report(input report_t r);
        r.gap = quiet_sender ? 0 : $urandom_range(0, MAX_IDLE);
        queued_reports.push_back(r);
        last_queued = r;
    endfunction

    function automatic key_code_t fresh_key();
        return key_code_t'($urandom_range(ERR_CODE_MAX + 1, 255));
    endfunction

    initial
    begin
        clk               = 1'b0;
        rst_n             = 1'b0;
        rpt_if.valid      = 1'b0;
        rpt_if.modifiers  = '0;
        rpt_if.key_slot_0 = '0;
        rpt_if.key_slot_1 = '0;
        rpt_if.key_slot_2 = '0;
        rpt_if.key_slot_3 = '0;
        rpt_if.key_slot_4 = '0;
        rpt_if.key_slot_5 = '0;
        evt_if.ready      = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        report_t     r;
        int unsigned n;
        int unsigned i;
        int unsigned kind;
        key_code_t   code;
        down_count    = 0;
        down_mods     = '0;
        reports_taken = 0;
        events_seen   = 0;
        error_count   = 0;
        quiet_sender  = 1'b0;
        foreach (down_keys[k])
            down_keys[k] = NO_KEY;

        queue_report(build(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        queue_report(build(8'hFF, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09));
        r = build(8'hFF, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09);
        r.drain = 1'b1;
        queue_report(r);
        queue_report(build(8'h00, 8'hFF, 8'hFE, 8'hFD, 8'hFC, 8'hFB, 8'h80));
        queue_report(build(8'h55, ERR_CODE_MAX - 8'd2, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        queue_report(build(8'h55, 8'h10, 8'h11, ERR_CODE_MAX - 8'd1, 8'h12, 8'h13, 8'h14));
        queue_report(build(8'h55, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24, ERR_CODE_MAX));
        queue_report(build(8'hAA, 8'h20, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00));
        queue_report(build(8'hAA, 8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00));
        queue_report(build(8'h55, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        queue_report(build(8'h81, 8'hE0, 8'hE7, 8'h00, 8'h00, 8'h00, 8'h00));
        queue_report(build(8'h81, 8'h00, 8'h04, 8'h00, 8'h05, 8'h00, 8'h06));
        queue_report(build(8'h80, 8'h05, 8'h04, 8'h06, 8'h07, 8'h00, 8'h00));
        queue_report(build(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        queue_report(build(8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, ERR_CODE_MAX - 8'd2));
        queue_report(build(8'h02, 8'hAB, 8'hCD, 8'hEF, 8'h00, 8'h00, 8'h00));
        queue_report(build(8'h7F, 8'hCD, 8'hAB, 8'h00, 8'hEF, 8'h33, 8'h00));
        queue_report(build(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            quiet_sender = (n >= 60 && n < 90);
            r = last_queued;
            r.drain = (n == 70);
            kind = $urandom_range(0, 9);
            if (kind <= 3 || kind == 5)
            begin
                for (i = 0; i < REPORT_SLOTS; i++)
                begin
                    case ($urandom_range(0, 5))
                        0: r.slot[i] = NO_KEY;
                        1: r.slot[i] = fresh_key();
                        2: r.slot[i] = r.slot[$urandom_range(0, REPORT_SLOTS - 1)];
                        default: ;
                    endcase
                end
                if ($urandom_range(0, 1))
                    r.mods[$urandom_range(0, MOD_BITS - 1)] ^= 1'b1;
                if (kind == 5)
                    r.slot[$urandom_range(0, REPORT_SLOTS - 1)] =
                        key_code_t'($urandom_range(1, ERR_CODE_MAX));
            end
            else if (kind == 6)
            begin
                r.mods = mod_byte_t'($urandom_range(0, 255));
                for (i = 0; i < REPORT_SLOTS; i++)
                    r.slot[i] = key_code_t'($urandom_range(0, 255));
            end
            else if (kind == 7)
            begin
                for (i = 0; i < REPORT_SLOTS; i++)
                    r.slot[i] = NO_KEY;
                r.slot[$urandom_range(0, REPORT_SLOTS - 1)] = fresh_key();
                r.slot[$urandom_range(0, REPORT_SLOTS - 1)] = fresh_key();
                r.mods = mod_byte_t'($urandom_range(0, 255));
            end
            else if (kind == 8)
            begin
                code = fresh_key();
                for (i = 0; i < REPORT_SLOTS; i++)
                begin
                    if ($urandom_range(0, 1))
                        r.slot[i] = code;
                end
            end
            else if (kind == 9)
            begin
                r.mods = mod_byte_t'($urandom_range(0, 255));
            end
            queue_report(r);
        end
        total_reports = queued_reports.size();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (reports_taken != total_reports)
            @(posedge clk);
        while (due_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rpt_if.valid <= 1'b0;
            idle_cycles  <= 0;
        end
        else
        begin
            if (rpt_if.valid && rpt_if.ready)
            begin
                diff_report(on_wire);
                reports_taken = reports_taken + 1;
            end
            if (!rpt_if.valid || rpt_if.ready)
            begin
                if (queued_reports.size() == 0)
                begin
                    rpt_if.valid <= 1'b0;
                end
                else if (idle_cycles < queued_reports[0].gap)
                begin
                    rpt_if.valid <= 1'b0;
                    idle_cycles  <= idle_cycles + 1;
                end
                else if (queued_reports[0].drain && due_events.size() != 0)
                begin
                    // hold off until the block has emptied
                    rpt_if.valid <= 1'b0;
                end
                else
                begin
                    on_wire = queued_reports.pop_front();
                    rpt_if.modifiers  <= on_wire.mods;
                    rpt_if.key_slot_0 <= on_wire.slot[0];
                    rpt_if.key_slot_1 <= on_wire.slot[1];
                    rpt_if.key_slot_2 <= on_wire.slot[2];
                    rpt_if.key_slot_3 <= on_wire.slot[3];
                    rpt_if.key_slot_4 <= on_wire.slot[4];
                    rpt_if.key_slot_5 <= on_wire.slot[5];
                    rpt_if.valid      <= 1'b1;
                    idle_cycles       <= 0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_if.ready <= 1'b0;
            stall_cycles <= 0;
        end
        else if (evt_if.valid && evt_if.ready)
        begin
            if (due_events.size() == 0)
            begin
                $display("%0t: unexpected event: rel=%0b code=%02h mods=%02h last=%0b",
                         $time, evt_if.is_release, evt_if.key_code,
                         evt_if.modifier_byte, evt_if.last_event);
                error_count = error_count + 1;
            end
            else if (evt_if.is_release    !== due_events[0].is_release ||
                     evt_if.key_code      !== due_events[0].key_code ||
                     evt_if.modifier_byte !== due_events[0].modifier_byte ||
                     evt_if.last_event    !== due_events[0].last_event)
            begin
                $display("%0t: event mismatch: expected rel=%0b code=%02h mods=%02h last=%0b, %s",
                         $time, due_events[0].is_release, due_events[0].key_code,
                         due_events[0].modifier_byte, due_events[0].last_event,
                         $sformatf("got rel=%0b code=%02h mods=%02h last=%0b",
                                   evt_if.is_release, evt_if.key_code,
                                   evt_if.modifier_byte, evt_if.last_event));
                error_count = error_count + 1;
                void'(due_events.pop_front());
            end
            else
            begin
                void'(due_events.pop_front());
            end
            events_seen = events_seen + 1;
            stall_draw = ((events_seen / 50) % 3 == 2) ? 0 : $urandom_range(0, MAX_IDLE);
            stall_cycles <= stall_draw;
            evt_if.ready <= (stall_draw == 0);
        end
        else if (stall_cycles != 0)
        begin
            stall_cycles <= stall_cycles - 1;
            evt_if.ready <= (stall_cycles == 1);
        end
        else
        begin
            evt_if.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial cycle_count = 0;

endmodule
